@@ sv/vcrt_pkg.sv @@
// Package for the video chunk reassembly tracker.
// Holds status and register codes, port widths, controller types and the id
// ordering helper. It has no dependencies.
`default_nettype none
package vcrt_pkg;

    localparam int S_TDATA_W = 224;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] ST_BAD_HEADER   = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH   = 3'd1;
    localparam logic [2:0] ST_BAD_GEOMETRY = 3'd2;
    localparam logic [2:0] ST_STALE        = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX    = 3'd4;
    localparam logic [2:0] ST_DUPLICATE    = 3'd5;
    localparam logic [2:0] ST_ACCEPTED     = 3'd6;
    localparam logic [2:0] ST_COMPLETED    = 3'd7;

    localparam logic REG_REORDER_WINDOW = 1'b0;
    localparam logic REG_CHUNK_HDR      = 1'b1;

    typedef enum logic [6:0] {
        FSM_IDLE    = 7'b0000001,
        FSM_CHECK   = 7'b0000010,
        FSM_RESOLVE = 7'b0000100,
        FSM_SCAN    = 7'b0001000,
        FSM_ALLOC   = 7'b0010000,
        FSM_MARK    = 7'b0100000,
        FSM_FINISH  = 7'b1000000
    } fsm_state_t;

    typedef struct packed {
        logic load_in;
        logic do_check;
        logic do_resolve;
        logic scan_step;
        logic do_alloc;
        logic do_mark;
        logic load_out;
    } vcrt_cmd_t;

    typedef struct packed {
        logic early_fail;
        logic stale;
        logic need_scan;
        logic scan_last;
        logic out_free;
    } vcrt_sts_t;

    // True when a is ahead of b in wrapping id order.
    function automatic logic id_newer(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage
`default_nettype wire

@@ sv/vcrt_ctrl.sv @@
// Sequencing state machine for the reassembly tracker.
// Depends on vcrt_pkg; drives commands to vcrt_datapath and reads its status.
`default_nettype none
module vcrt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  vcrt_pkg::vcrt_sts_t     sts,
    output vcrt_pkg::vcrt_cmd_t     cmd
);
    import vcrt_pkg::*;

    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = FSM_CHECK;
                end
            end
            FSM_CHECK: begin
                cmd.do_check = 1'b1;
                state_next   = sts.early_fail ? FSM_FINISH : FSM_RESOLVE;
            end
            FSM_RESOLVE: begin
                cmd.do_resolve = 1'b1;
                if (sts.stale) begin
                    state_next = FSM_FINISH;
                end else if (sts.need_scan) begin
                    state_next = FSM_SCAN;
                end else begin
                    state_next = FSM_ALLOC;
                end
            end
            FSM_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = FSM_ALLOC;
                end
            end
            FSM_ALLOC: begin
                cmd.do_alloc = 1'b1;
                state_next   = FSM_MARK;
            end
            FSM_MARK: begin
                cmd.do_mark = 1'b1;
                state_next  = FSM_FINISH;
            end
            FSM_FINISH: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/vcrt_datapath.sv @@
// Datapath of the reassembly tracker: header checks, slot table, age scan,
// chunk bitmap memory and the output register. Depends on vcrt_pkg.
`default_nettype none
module vcrt_datapath #(
    parameter int SLOTS      = 32,
    parameter int MAX_CHUNKS = 256
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [vcrt_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [vcrt_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_addr,
    input  wire logic [vcrt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  vcrt_pkg::vcrt_cmd_t                 cmd,
    output vcrt_pkg::vcrt_sts_t                 sts,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [vcrt_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [vcrt_pkg::M_TUSER_W-1:0]      m_tuser
);
    import vcrt_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int TW = $clog2(MAX_CHUNKS + 1);
    localparam logic [16:0]   MAXC17    = 17'(MAX_CHUNKS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    // Configuration registers.
    logic [15:0] window_reg;
    logic [7:0]  hdr_bytes_reg;

    // Captured header.
    logic        hok_reg, mview_reg;
    logic [15:0] psize_reg, ctot_reg, cnum_reg;
    logic [10:0] csize_reg;
    logic [31:0] coff_reg, fsize_reg, fnum_reg;
    logic [63:0] ptime_reg;

    // Slot table and global tracking state.
    logic [SLOTS-1:0] valid_reg;
    logic [31:0]      sfn_reg   [SLOTS];
    logic [TW-1:0]    stot_reg  [SLOTS];
    logic [TW-1:0]    srcv_reg  [SLOTS];
    logic [63:0]      sfirst_reg[SLOTS];
    logic [63:0]      slatest_reg[SLOTS];
    logic [31:0]      sorder_reg[SLOTS];
    logic [31:0]      seq_reg;
    logic             hc_reg;
    logic [31:0]      ldn_reg;
    logic [63:0]      ldt_reg;
    logic [31:0]      rcnt_reg;

    // Chunk bitmap: one row per slot.
    logic [MAX_CHUNKS-1:0] bitmap_mem[SLOTS];
    logic [MAX_CHUNKS-1:0] bm_q_reg;

    // Per-item working registers.
    logic [SLOTS-1:0] match_reg;
    logic             eq_reg, lt_reg, win_ok_reg, newer_reg, tlater_reg, ldt_nz_reg;
    logic             hit_reg, restart_reg, fresh_reg;
    logic [SW-1:0]    sel_reg, scan_idx_reg;
    logic [31:0]      best_reg;

    // Result being built.
    logic [2:0]  res_status_reg;
    logic [4:0]  res_slot_reg;
    logic [31:0] res_woff_reg, res_dnum_reg;
    logic        res_restarted_reg;
    logic [63:0] res_dtime_reg;
    logic        out_valid_reg;

    // Header checks.
    logic [16:0] len_sum;
    logic [32:0] end_byte;
    logic        len_bad, geo_bad;
    logic [2:0]  early_code;

    assign len_sum  = {9'd0, hdr_bytes_reg} + {6'd0, csize_reg};
    assign len_bad  = ({1'b0, psize_reg} != len_sum);
    assign end_byte = {1'b0, coff_reg} + {22'd0, csize_reg};
    assign geo_bad  = (ctot_reg == 16'd0) || ({1'b0, ctot_reg} > MAXC17) ||
                      (fsize_reg == 32'd0) || (end_byte > {1'b0, fsize_reg});
    always_comb begin
        if (!hok_reg) begin
            early_code = ST_BAD_HEADER;
        end else if (len_bad) begin
            early_code = ST_BAD_LENGTH;
        end else begin
            early_code = ST_BAD_GEOMETRY;
        end
    end

    // Lookup resolution.
    logic          hit, any_free, miss_guard, recent, rs, stale_c, restart_c, need_scan;
    logic [SW-1:0] hit_idx, free_idx;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                hit_idx = SW'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = SW'(i);
            end
        end
    end

    assign hit        = |match_reg;
    assign any_free   = ~&valid_reg;
    assign miss_guard = !hit && hc_reg && !newer_reg;
    assign recent     = lt_reg && win_ok_reg;
    assign rs         = ldt_nz_reg && lt_reg && tlater_reg;
    assign stale_c    = miss_guard && (eq_reg || ((!mview_reg || !recent) && !rs));
    assign restart_c  = miss_guard && !eq_reg && (!mview_reg || !recent) && rs;
    assign need_scan  = !hit && !stale_c && !restart_c && !any_free;

    // Eviction age of the slot under scan.
    logic [31:0] scan_age;
    assign scan_age = seq_reg - sorder_reg[scan_idx_reg];

    // Bitmap update.
    logic [CW-1:0]         cidx;
    logic [TW-1:0]         tot_sel, cnt1;
    logic [MAX_CHUNKS-1:0] row, onehot;
    logic                  bad_idx, dup, complete;

    assign cidx     = cnum_reg[CW-1:0];
    assign tot_sel  = stot_reg[sel_reg];
    assign bad_idx  = (cnum_reg >= 16'(tot_sel));
    assign row      = fresh_reg ? '0 : bm_q_reg;
    assign onehot   = {{(MAX_CHUNKS - 1){1'b0}}, 1'b1} << cidx;
    assign dup      = row[cidx];
    assign cnt1     = srcv_reg[sel_reg] + TW'(1);
    assign complete = (cnt1 == tot_sel);

    assign sts.early_fail = !hok_reg || len_bad || geo_bad;
    assign sts.stale      = stale_c;
    assign sts.need_scan  = need_scan;
    assign sts.scan_last  = (scan_idx_reg == LAST_SLOT);
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= 16'd256;
            hdr_bytes_reg <= 8'd32;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_REORDER_WINDOW: window_reg <= cfg_wr_data;
                REG_CHUNK_HDR:      hdr_bytes_reg <= cfg_wr_data[7:0];
                default:            ;
            endcase
        end
    end

    // Control state of the tracker.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            seq_reg       <= '0;
            hc_reg        <= 1'b0;
            ldn_reg       <= '0;
            ldt_reg       <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.do_alloc && !hit_reg) begin
                if (restart_reg) begin
                    rcnt_reg  <= rcnt_reg + 32'd1;
                    hc_reg    <= 1'b0;
                    ldn_reg   <= '0;
                    ldt_reg   <= '0;
                end
                // A restart drops every slot before the new one is taken.
                valid_reg <= (restart_reg ? '0 : valid_reg) | (SLOTS'(1) << sel_reg);
                seq_reg   <= seq_reg + 32'd1;
            end
            if (cmd.do_mark && !bad_idx && !dup && complete) begin
                valid_reg[sel_reg] <= 1'b0;
                hc_reg             <= 1'b1;
                if (!hc_reg || id_newer(sfn_reg[sel_reg], ldn_reg)) begin
                    ldn_reg <= sfn_reg[sel_reg];
                end
                if (slatest_reg[sel_reg] > ldt_reg) begin
                    ldt_reg <= slatest_reg[sel_reg];
                end
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            hok_reg   <= s_tuser[0];
            mview_reg <= s_tuser[1];
            psize_reg <= s_tdata[15:0];
            csize_reg <= s_tdata[26:16];
            coff_reg  <= s_tdata[58:27];
            fsize_reg <= s_tdata[90:59];
            ctot_reg  <= s_tdata[106:91];
            cnum_reg  <= s_tdata[122:107];
            fnum_reg  <= s_tdata[154:123];
            ptime_reg <= s_tdata[218:155];
        end

        if (cmd.do_check) begin
            for (int i = 0; i < SLOTS; i++) begin
                match_reg[i] <= valid_reg[i] && (sfn_reg[i] == fnum_reg);
            end
            eq_reg            <= (fnum_reg == ldn_reg);
            lt_reg            <= (fnum_reg < ldn_reg);
            win_ok_reg        <= ((ldn_reg - fnum_reg) <= {16'd0, window_reg});
            newer_reg         <= id_newer(fnum_reg, ldn_reg);
            tlater_reg        <= (ptime_reg > ldt_reg);
            ldt_nz_reg        <= (ldt_reg != 64'd0);
            res_status_reg    <= early_code;
            res_slot_reg      <= '0;
            res_woff_reg      <= '0;
            res_restarted_reg <= 1'b0;
            res_dnum_reg      <= '0;
            res_dtime_reg     <= '0;
        end

        if (cmd.do_resolve) begin
            hit_reg      <= hit;
            restart_reg  <= restart_c;
            best_reg     <= '0;
            scan_idx_reg <= '0;
            if (hit) begin
                sel_reg <= hit_idx;
            end else if (!restart_c && any_free) begin
                sel_reg <= free_idx;
            end else begin
                sel_reg <= '0;
            end
            if (stale_c) begin
                res_status_reg <= ST_STALE;
            end
        end

        // Oldest-allocated search; a tie keeps the lower slot.
        if (cmd.scan_step) begin
            if (scan_age > best_reg) begin
                best_reg <= scan_age;
                sel_reg  <= scan_idx_reg;
            end
            scan_idx_reg <= scan_idx_reg + SW'(1);
        end

        if (cmd.do_alloc) begin
            fresh_reg <= !hit_reg;
            bm_q_reg  <= bitmap_mem[sel_reg];
            if (!hit_reg) begin
                sfn_reg[sel_reg]     <= fnum_reg;
                stot_reg[sel_reg]    <= ctot_reg[TW-1:0];
                srcv_reg[sel_reg]    <= '0;
                sfirst_reg[sel_reg]  <= ptime_reg;
                slatest_reg[sel_reg] <= ptime_reg;
                sorder_reg[sel_reg]  <= seq_reg;
                res_restarted_reg    <= restart_reg;
            end else if (ptime_reg > slatest_reg[sel_reg]) begin
                slatest_reg[sel_reg] <= ptime_reg;
            end
        end

        if (cmd.do_mark) begin
            res_slot_reg <= 5'(sel_reg);
            // A fresh row is always rewritten so that old bits never leak.
            if (fresh_reg || (!bad_idx && !dup)) begin
                bitmap_mem[sel_reg] <= row | (bad_idx ? '0 : onehot);
            end
            if (bad_idx) begin
                res_status_reg <= ST_BAD_INDEX;
            end else if (dup) begin
                res_status_reg <= ST_DUPLICATE;
            end else begin
                srcv_reg[sel_reg] <= cnt1;
                res_woff_reg      <= coff_reg;
                if (complete) begin
                    res_status_reg <= ST_COMPLETED;
                    res_dnum_reg   <= sfn_reg[sel_reg];
                    res_dtime_reg  <= sfirst_reg[sel_reg];
                end else begin
                    res_status_reg <= ST_ACCEPTED;
                end
            end
        end

        if (cmd.load_out) begin
            m_tdata <= {3'd0, rcnt_reg, res_dtime_reg, res_dnum_reg, res_woff_reg,
                        res_slot_reg};
            m_tuser <= {res_restarted_reg, res_status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

@@ sv/video_chunk_reassembly_tracker_core.sv @@
// Top level of the video chunk reassembly tracker.
// Depends on vcrt_pkg, vcrt_ctrl and vcrt_datapath.
`default_nettype none
// The block takes one parsed chunk header per input transaction and returns
// exactly one result transaction for it. A header is taken, then checked,
// resolved against the slot table, allocated or updated, and marked in the
// chunk bitmap. When every slot is busy and a new frame needs a slot, the
// oldest-allocated slot is found by a scan of one slot per cycle. Headers
// rejected by the header, length or geometry checks skip the later steps,
// and stale headers stop after resolution. The controller steps one header
// at a time through this sequence. The chunk bitmap is a memory of SLOTS
// rows of MAX_CHUNKS bits; a row is rewritten when its slot is allocated, so
// no clearing pass follows reset. A finished result waits in the output
// register while the next header is taken. Configuration writes are to be
// made only while the block is idle; the block itself does not enforce this.
module video_chunk_reassembly_tracker_core #(
    parameter int SLOTS      = 32,
    parameter int MAX_CHUNKS = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // stated payload bytes, chunk bytes, chunk offset, frame bytes, chunk total,
    // chunk number, frame number, packet time, then zero fill
    input  wire logic [vcrt_pkg::S_TDATA_W-1:0]  s_tdata,
    // header_ok, multi_view
    input  wire logic [vcrt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // slot, write_offset, done_frame_number, done_frame_time, restart_total,
    // then zero fill
    output logic [vcrt_pkg::M_TDATA_W-1:0]       m_tdata,
    // status, restarted
    output logic [vcrt_pkg::M_TUSER_W-1:0]       m_tuser,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_addr,
    input  wire logic [vcrt_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import vcrt_pkg::*;

    vcrt_cmd_t cmd;
    vcrt_sts_t sts;

    vcrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vcrt_datapath #(
        .SLOTS      (SLOTS),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire

@@ sv/vcrt_checker.sv @@
// Port-level checks for the reassembly tracker and the bind that attaches them.
// Depends on vcrt_pkg and video_chunk_reassembly_tracker_core.
`default_nettype none
module vcrt_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [vcrt_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [vcrt_pkg::M_TUSER_W-1:0] m_tuser
);
    import vcrt_pkg::*;

    logic [2:0] st;
    logic       early;
    assign st    = m_tuser[2:0];
    assign early = (st == ST_BAD_HEADER) || (st == ST_BAD_LENGTH) ||
                   (st == ST_BAD_GEOMETRY) || (st == ST_STALE);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_early_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && early |-> m_tdata[4:0] == 5'd0 && m_tdata[36:5] == 32'd0)
        else $error("rejected chunk reports a slot or offset");

    a_done_only_on_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != ST_COMPLETED |-> m_tdata[68:37] == 32'd0 &&
        m_tdata[132:69] == 64'd0)
        else $error("frame done fields set without completion");

    a_restart_allocates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> !early)
        else $error("restart reported on a rejected chunk");

endmodule

bind video_chunk_reassembly_tracker_core vcrt_checker u_vcrt_checker (.*);
`default_nettype wire
